// ===== hdl/two_point_spring_force_macros.svh =====
// assertion macros shared by the spring force checker
`ifndef TWO_POINT_SPRING_FORCE_MACROS_SVH
`define TWO_POINT_SPRING_FORCE_MACROS_SVH

// clocked assertion, held off while reset is asserted
`define TPSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TPSF_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tpsf_pkg.sv =====
// shared widths, types and register codes for the spring force block
`timescale 1ns / 1ps

package tpsf_pkg;

	// number format
	localparam int FRAC_BITS   = 16;
	localparam int COORD_WIDTH = 32;
	localparam int REG_W       = 31;

	// derived datapath widths
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int SUM_W  = SQ_W;
	localparam int LEN_W  = SUM_W / 2;
	localparam int REM_W  = LEN_W + 2;
	localparam int PROD_W = REG_W + LEN_W;
	localparam int MAG_W  = PROD_W - FRAC_BITS;
	localparam int LO_W   = MAG_W / 2;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int NUM_W  = MAG_W + DIFF_W;

	// pipeline depth: three front stages, root steps, three scale stages,
	// quotient steps, output stage
	localparam int SQ_STEPS  = LEN_W;
	localparam int DIV_STEPS = COORD_WIDTH;
	localparam int LATENCY   = 3 + SQ_STEPS + 3 + DIV_STEPS + 1;

	// stream widths
	localparam int IN_W   = 6 * COORD_WIDTH;
	localparam int OUT_W  = 3 * COORD_WIDTH;
	localparam int USER_W = 8;

	// configuration register codes
	localparam logic REG_REST = 1'b0;
	localparam logic REG_K    = 1'b1;

	// per-item info that rides alongside the root extraction
	typedef struct packed {
		logic [2:0][DIFF_W-1:0] ad;
		logic [2:0]             pos;
		logic [2:0]             neg;
		logic                   zero;
	} sq_side_t;

	// per-item info that rides alongside the quotient steps
	typedef struct packed {
		logic [2:0] neg;
		logic [2:0] ovf;
		logic       zero;
	} dv_side_t;

endpackage

// ===== hdl/tpsf_sqrt.sv =====
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module tpsf_sqrt (
	input  logic                           clk,
	input  logic                           en,
	input  logic [tpsf_pkg::SUM_W-1:0]     rad,
	output logic [tpsf_pkg::LEN_W-1:0]     root
);

	localparam int N = tpsf_pkg::SQ_STEPS;

	logic [tpsf_pkg::SUM_W-1:0] rad_s  [0:N-1];
	logic [tpsf_pkg::REM_W-1:0] rem_s  [0:N-1];
	logic [tpsf_pkg::LEN_W-1:0] root_s [0:N];

	// first step reads the incoming radicand
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [tpsf_pkg::REM_W-1:0] cur;
		logic [tpsf_pkg::REM_W-1:0] trial;
		logic                       take;

		// bring down two radicand bits and try the next root bit
		always_comb begin
			cur   = {rem_s[i][tpsf_pkg::REM_W-3:0], rad_s[i][tpsf_pkg::SUM_W-1 -: 2]};
			trial = {root_s[i], 2'b01};
			take  = (cur >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[i+1] <= {root_s[i][tpsf_pkg::LEN_W-2:0], take};
			end
		end

		if (i < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1] <= take ? cur - trial : cur;
					rad_s[i+1] <= {rad_s[i][tpsf_pkg::SUM_W-3:0], 2'b00};
				end
			end
		end
	end

	assign root = root_s[N];

endmodule

// ===== hdl/tpsf_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module tpsf_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic [tpsf_pkg::LEN_W-1:0]       den,
	input  logic [tpsf_pkg::LEN_W-1:0]       rem0,
	input  logic [tpsf_pkg::COORD_WIDTH-1:0] low,
	output logic [tpsf_pkg::COORD_WIDTH-1:0] quo
);

	localparam int N  = tpsf_pkg::DIV_STEPS;
	localparam int CW = tpsf_pkg::COORD_WIDTH;
	localparam int LW = tpsf_pkg::LEN_W;

	logic [LW-1:0] den_s [0:N-1];
	logic [LW-1:0] rem_s [0:N-1];
	logic [CW-1:0] low_s [0:N-1];
	logic [CW-1:0] quo_s [0:N];

	assign den_s[0] = den;
	assign rem_s[0] = rem0;
	assign low_s[0] = low;
	assign quo_s[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [LW:0] cur;
		logic        take;

		// shift in the next numerator bit and try a subtract
		always_comb begin
			cur  = {rem_s[i], low_s[i][CW-1]};
			take = (cur >= {1'b0, den_s[i]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i+1] <= {quo_s[i][CW-2:0], take};
			end
		end

		if (i < N - 1) begin : g_carry
			logic [LW:0] diff;
			assign diff = cur - {1'b0, den_s[i]};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1] <= take ? diff[LW-1:0] : cur[LW-1:0];
					low_s[i+1] <= {low_s[i][CW-2:0], 1'b0};
					den_s[i+1] <= den_s[i];
				end
			end
		end
	end

	assign quo = quo_s[N];

endmodule

// ===== hdl/two_point_spring_force.sv =====
// spring force between two points, top level
`timescale 1ns / 1ps
// Hooke's law spring force between a particle and the other spring end.
// Input stream s_*: one word carries pos_x, pos_y, pos_z, end_x, end_y,
// end_z as signed Q16.16, accepted when s_tvalid and s_tready are high.
// Output stream m_*: one word per input word with force_x, force_y, force_z
// (signed Q16.16, saturated) in m_tdata and the flags zero_separation and
// clipped in m_tuser. Results leave in input order.
// Configuration: cfg_we writes rest_length (index 0) or spring_constant
// (index 1), both unsigned Q15.16; write only while the pipeline is empty.
// The pipeline has 72 register stages: three front stages, 33 root stages
// (one bit of the separation length each), three scaling stages, 32 quotient
// stages (one force bit each) and the output register.
// Throughput is one word per cycle while m_tready stays high.
// Reset clears every valid bit and loads both registers with 1.0.
// When the receiver stalls a full output holds, the whole pipeline freezes
// and s_tready drops; no word is lost or repeated.

module two_point_spring_force (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// pos_x, pos_y, pos_z, end_x, end_y, end_z
	input  logic [tpsf_pkg::IN_W-1:0]       s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// force_x, force_y, force_z
	output logic [tpsf_pkg::OUT_W-1:0]      m_tdata,
	// zero_separation, clipped, zero fill
	output logic [tpsf_pkg::USER_W-1:0]     m_tuser,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [tpsf_pkg::REG_W-1:0]      cfg_data
);

	localparam int CW = tpsf_pkg::COORD_WIDTH;
	localparam int DW = tpsf_pkg::DIFF_W;
	localparam int LW = tpsf_pkg::LEN_W;
	localparam logic [CW-1:0] NEG_LIM = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] POS_LIM = ~NEG_LIM;

	logic en;
	logic [tpsf_pkg::LATENCY-1:0] vld_q;
	logic [tpsf_pkg::REG_W-1:0] rest_q, kcon_q;

	// pipeline advances unless a finished word is stalled
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[tpsf_pkg::LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[tpsf_pkg::LATENCY-2:0], s_tvalid};
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q <= tpsf_pkg::REG_W'(65536);
			kcon_q <= tpsf_pkg::REG_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tpsf_pkg::REG_REST: rest_q <= cfg_data;
				tpsf_pkg::REG_K:    kcon_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	// stage 1: separation per axis
	logic [2:0][DW-1:0] d_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= {s_tdata[CW*k + CW-1], s_tdata[CW*k +: CW]}
					- {s_tdata[CW*(k+3) + CW-1], s_tdata[CW*(k+3) +: CW]};
			end
		end
	end

	// stage 2: magnitude and square per axis
	logic [2:0][tpsf_pkg::SQ_W-1:0] sq_s2;
	tpsf_pkg::sq_side_t side_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic [DW-1:0] a;
				a = d_s1[k][DW-1] ? -d_s1[k] : d_s1[k];
				sq_s2[k]       <= tpsf_pkg::SQ_W'(a) * tpsf_pkg::SQ_W'(a);
				side_s2.ad[k]  <= a;
				side_s2.neg[k] <= d_s1[k][DW-1];
				side_s2.pos[k] <= !d_s1[k][DW-1] && (d_s1[k] != '0);
			end
			side_s2.zero <= (d_s1 == '0);
		end
	end

	// stage 3: squared length
	logic [tpsf_pkg::SUM_W-1:0] sum_s3;
	tpsf_pkg::sq_side_t sqd_s [0:tpsf_pkg::SQ_STEPS];
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3   <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sqd_s[0] <= side_s2;
		end
	end

	// length by root extraction, side info delayed to match
	logic [LW-1:0] len;
	tpsf_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s3),
		.root (len)
	);

	for (genvar j = 0; j < tpsf_pkg::SQ_STEPS; j++) begin : g_sqd
		always_ff @(posedge clk) begin
			if (en) begin
				sqd_s[j+1] <= sqd_s[j];
			end
		end
	end

	// scale stage 1: magnitude k * |L - rest|
	logic [tpsf_pkg::MAG_W-1:0] mag_m1;
	logic [LW-1:0]              len_m1;
	logic                       str_m1;
	tpsf_pkg::sq_side_t         side_m1;
	always_ff @(posedge clk) begin
		if (en) begin
			logic [LW-1:0]               rl, df;
			logic [tpsf_pkg::PROD_W-1:0] pr;
			rl = LW'(rest_q);
			df = (len > rl) ? len - rl : rl - len;
			pr = tpsf_pkg::PROD_W'(kcon_q) * tpsf_pkg::PROD_W'(df);
			mag_m1  <= pr[tpsf_pkg::PROD_W-1:tpsf_pkg::FRAC_BITS];
			str_m1  <= (len > rl);
			len_m1  <= len;
			side_m1 <= sqd_s[tpsf_pkg::SQ_STEPS];
		end
	end

	// scale stage 2: magnitude times axis distance, in two halves
	logic [2:0][tpsf_pkg::LO_W+DW-1:0] plo_m2;
	logic [2:0][tpsf_pkg::HI_W+DW-1:0] phi_m2;
	logic [LW-1:0]      len_m2;
	logic               str_m2;
	tpsf_pkg::sq_side_t side_m2;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				plo_m2[k] <= (tpsf_pkg::LO_W+DW)'(mag_m1[tpsf_pkg::LO_W-1:0])
					* (tpsf_pkg::LO_W+DW)'(side_m1.ad[k]);
				phi_m2[k] <= (tpsf_pkg::HI_W+DW)'(mag_m1[tpsf_pkg::MAG_W-1:tpsf_pkg::LO_W])
					* (tpsf_pkg::HI_W+DW)'(side_m1.ad[k]);
			end
			len_m2  <= len_m1;
			str_m2  <= str_m1;
			side_m2 <= side_m1;
		end
	end

	// scale stage 3: full numerator, quotient overflow check, force sign
	logic [2:0][LW-1:0] rem_m3;
	logic [2:0][CW-1:0] low_m3;
	logic [LW-1:0]      len_m3;
	tpsf_pkg::dv_side_t dvd_s [0:tpsf_pkg::DIV_STEPS];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				logic [tpsf_pkg::NUM_W-1:0] num;
				num = {phi_m2[k], {tpsf_pkg::LO_W{1'b0}}}
					+ tpsf_pkg::NUM_W'(plo_m2[k]);
				rem_m3[k]       <= num[CW+LW-1:CW];
				low_m3[k]       <= num[CW-1:0];
				dvd_s[0].ovf[k] <= (num[tpsf_pkg::NUM_W-1:CW]
					>= (tpsf_pkg::NUM_W-CW)'(len_m2));
				dvd_s[0].neg[k] <= str_m2 ? side_m2.pos[k] : side_m2.neg[k];
			end
			dvd_s[0].zero <= side_m2.zero;
			len_m3        <= len_m2;
		end
	end

	// per-axis quotient by the length
	logic [2:0][CW-1:0] quo;
	for (genvar k = 0; k < 3; k++) begin : g_div
		tpsf_div u_div (
			.clk  (clk),
			.en   (en),
			.den  (len_m3),
			.rem0 (rem_m3[k]),
			.low  (low_m3[k]),
			.quo  (quo[k])
		);
	end

	for (genvar j = 0; j < tpsf_pkg::DIV_STEPS; j++) begin : g_dvd
		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[j+1] <= dvd_s[j];
			end
		end
	end

	// output stage: saturate, apply sign, flags
	tpsf_pkg::dv_side_t dvo;
	assign dvo = dvd_s[tpsf_pkg::DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			logic [CW-1:0] lim, qv;
			logic          sat, clip;
			clip = 1'b0;
			for (int k = 0; k < 3; k++) begin
				lim = dvo.neg[k] ? NEG_LIM : POS_LIM;
				sat = dvo.ovf[k] || (quo[k] > lim);
				qv  = sat ? lim : quo[k];
				if (dvo.zero) begin
					m_tdata[CW*k +: CW] <= '0;
				end else begin
					m_tdata[CW*k +: CW] <= dvo.neg[k] ? -qv : qv;
					clip = clip | sat;
				end
			end
			m_tuser <= {{(tpsf_pkg::USER_W-2){1'b0}}, clip, dvo.zero};
		end
	end

endmodule

// ===== hdl/tpsf_check.sv =====
// port-level checker for the spring force block, bound to the top level
`timescale 1ns / 1ps
`include "two_point_spring_force_macros.svh"

module tpsf_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tpsf_pkg::OUT_W-1:0]      m_tdata,
	input logic [tpsf_pkg::USER_W-1:0]     m_tuser
);

	localparam int CW = tpsf_pkg::COORD_WIDTH;
	localparam logic [CW-1:0] NEG_LIM = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] POS_LIM = ~NEG_LIM;

	// a stalled word stays put
	`TPSF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

	// input is taken exactly when the output side can move
	`TPSF_ASSERT_ALWAYS(a_ready_link, arst_n |-> (s_tready == (!m_tvalid || m_tready)), "input ready does not follow output side")

	// coincident points give zero force and no clipping
	`TPSF_ASSERT(a_zero_force, m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1], "zero separation with nonzero force")

	// clipping leaves at least one component at a bound
	`TPSF_ASSERT(a_clip_bound, m_tvalid && m_tuser[1] |-> (m_tdata[CW-1:0] == POS_LIM) || (m_tdata[CW-1:0] == NEG_LIM) || (m_tdata[2*CW-1:CW] == POS_LIM) || (m_tdata[2*CW-1:CW] == NEG_LIM) || (m_tdata[3*CW-1:2*CW] == POS_LIM) || (m_tdata[3*CW-1:2*CW] == NEG_LIM), "clipped flag without saturated component")

endmodule

bind two_point_spring_force tpsf_check u_tpsf_check (.*);

// ===== test/tb_two_point_spring_force.sv =====
// self-checking testbench for the two-point spring force block
`timescale 1ns / 1ps

module tb_two_point_spring_force;

	localparam int LIMIT = 600000;

	// one result word as predicted
	typedef struct {
		logic [31:0] fx, fy, fz;
		logic        zs, clip;
	} force_t;

	logic                          clk, arst_n;
	logic                          s_tvalid, s_tready;
	logic [tpsf_pkg::IN_W-1:0]     s_tdata;
	logic                          m_tvalid, m_tready;
	logic [tpsf_pkg::OUT_W-1:0]    m_tdata;
	logic [tpsf_pkg::USER_W-1:0]   m_tuser;
	logic                          cfg_we, cfg_index;
	logic [tpsf_pkg::REG_W-1:0]    cfg_data;

	logic [tpsf_pkg::IN_W-1:0] pending_words[$];
	force_t          expected_forces[$];
	logic [30:0]     rest_q, k_q;
	int              fails = 0, cycles = 0;
	int              in_gap, out_gap;
	bit              no_idle;

	two_point_spring_force uut (.*);

	always #5 clk = ~clk;

	// integer square root, floor
	function automatic logic [63:0] isqrt(logic [127:0] n);
		logic [63:0]  r;
		logic [127:0] c;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = {64'd0, r | (64'd1 << b)};
			if (c * c <= n) r = c[63:0];
		end
		return r;
	endfunction

	// expected force for one input word under the current registers
	function automatic force_t spring_force(logic [tpsf_pkg::IN_W-1:0] w);
		force_t            f;
		logic signed [32:0] d[3];
		logic [32:0]       ad[3];
		logic [127:0]      sum, len, diff, mag, a, b, t;
		logic [255:0]      q;
		logic [31:0]       lim, v[3];
		bit                stretched, neg;
		sum = 0;
		f.clip = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = {w[32*i+31], w[32*i +: 32]} - {w[32*(i+3)+31], w[32*(i+3) +: 32]};
			ad[i] = d[i] < 0 ? -d[i] : d[i];
			t = 128'(ad[i]);
			sum += t * t;
			v[i] = 0;
		end
		f.zs = (sum == 0);
		if (!f.zs) begin
			len = 128'(isqrt(sum));
			stretched = len > rest_q;
			diff = stretched ? len - rest_q : rest_q - len;
			mag = (k_q * diff) >> tpsf_pkg::FRAC_BITS;
			a = mag / len;
			b = mag % len;
			for (int i = 0; i < 3; i++) begin
				if (d[i] != 0) begin
					neg = stretched ? (d[i] > 0) : (d[i] < 0);
					lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
					q = {128'b0, a} * ad[i] + ({128'b0, b} * ad[i]) / len;
					if (q > lim) begin
						q = 256'(lim);
						f.clip = 1;
					end
					v[i] = neg ? -q[31:0] : q[31:0];
				end
			end
		end
		f.fx = v[0];
		f.fy = v[1];
		f.fz = v[2];
		return f;
	endfunction

	function automatic logic [tpsf_pkg::IN_W-1:0] word6(logic [31:0] px, py, pz, ex, ey, ez);
		return {ez, ey, ex, pz, py, px};
	endfunction

	function automatic int pick_gap();
		if (no_idle || $urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		fails++;
	endtask

	// driver: present queued words, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		bit vld;
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			in_gap <= 0;
		end else begin
			vld = s_tvalid;
			if (s_tvalid && s_tready) begin
				expected_forces.push_back(spring_force(s_tdata));
				vld = 0;
			end
			if (!vld) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
				end else if (pending_words.size() > 0) begin
					s_tdata <= pending_words.pop_front();
					vld = 1;
					in_gap <= pick_gap();
				end
			end
			s_tvalid <= vld;
		end
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			out_gap <= 0;
		end else if (out_gap > 0) begin
			m_tready <= 0;
			out_gap <= out_gap - 1;
		end else begin
			m_tready <= 1;
			out_gap <= pick_gap();
		end
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk) begin
		force_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_forces.size() == 0) begin
				report("unexpected word", m_tdata[31:0], 32'd0);
			end else begin
				e = expected_forces.pop_front();
				if (m_tdata[31:0] !== e.fx) report("force_x", m_tdata[31:0], e.fx);
				if (m_tdata[63:32] !== e.fy) report("force_y", m_tdata[63:32], e.fy);
				if (m_tdata[95:64] !== e.fz) report("force_z", m_tdata[95:64], e.fz);
				if (m_tuser[0] !== e.zs)
					report("zero_separation", 32'(m_tuser[0]), 32'(e.zs));
				if (m_tuser[1] !== e.clip)
					report("clipped", 32'(m_tuser[1]), 32'(e.clip));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_two_point_spring_force: FAIL");
			$finish;
		end
	end

	task automatic wait_idle();
		wait (pending_words.size() == 0 && !s_tvalid && expected_forces.size() == 0);
		repeat (tpsf_pkg::LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == tpsf_pkg::REG_REST) rest_q = val;
		else k_q = val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
		endcase
	endfunction

	task automatic random_words(int n);
		logic [31:0] p[3], o[3];
		for (int j = 0; j < n; j++) begin
			for (int i = 0; i < 3; i++) begin
				p[i] = rnd_coord();
				o[i] = rnd_coord();
			end
			case ($urandom_range(0, 9))
				0: o = p;
				1: begin o[1] = p[1]; o[2] = p[2]; end
				2: begin o[0] = p[0]; o[2] = p[2]; end
				default: ;
			endcase
			pending_words.push_back(word6(p[0], p[1], p[2], o[0], o[1], o[2]));
		end
	endtask

	initial begin
		logic [31:0] mx, mn;
		mx = 32'h7fff_ffff;
		mn = 32'h8000_0000;
		clk = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = tpsf_pkg::REG_REST;
		cfg_data = 0;
		no_idle = 0;
		rest_q = 31'd65536;
		k_q = 31'd65536;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed words at reset values
		pending_words.push_back(word6(0, 0, 0, 0, 0, 0));
		pending_words.push_back(word6(mx, mx, mx, mx, mx, mx));
		pending_words.push_back(word6(32'h1_0000, 0, 0, 0, 0, 0));
		pending_words.push_back(word6(0, 32'hffff_0000, 0, 0, 0, 0));
		pending_words.push_back(word6(32'h8000, 0, 0, 0, 0, 0));
		pending_words.push_back(word6(32'h3_0000, 32'h4_0000, 0, 0, 0, 0));
		pending_words.push_back(word6(mx, mx, mx, mn, mn, mn));
		pending_words.push_back(word6(mn, mn, mn, mx, mx, mx));
		pending_words.push_back(word6(mx, 0, 0, mn, 0, 0));
		pending_words.push_back(word6(0, 0, 1, 0, 0, 0));
		pending_words.push_back(word6(mn, 0, 0, 0, 0, 0));
		pending_words.push_back(word6(32'h1000, 32'h2000, 32'hffff_f000, 0, 32'h10, 0));
		random_words(60);
		wait_idle();

		// extremes of both registers
		write_reg(tpsf_pkg::REG_REST, 31'h7fff_ffff);
		write_reg(tpsf_pkg::REG_K, 31'h7fff_ffff);
		pending_words.push_back(word6(mx, mx, mx, mn, mn, mn));
		pending_words.push_back(word6(0, 0, 1, 0, 0, 0));
		pending_words.push_back(word6(mx, 0, 0, mn, 0, 0));
		random_words(80);
		wait_idle();

		write_reg(tpsf_pkg::REG_REST, 31'd0);
		write_reg(tpsf_pkg::REG_K, 31'd0);
		random_words(50);
		wait_idle();

		write_reg(tpsf_pkg::REG_K, 31'h7fff_ffff);
		no_idle = 1;
		random_words(80);
		wait_idle();
		no_idle = 0;

		write_reg(tpsf_pkg::REG_REST, 31'h2_0000);
		write_reg(tpsf_pkg::REG_K, 31'h3_0000);
		pending_words.push_back(word6(32'h2_0000, 0, 0, 0, 0, 0));
		random_words(100);
		wait_idle();

		write_reg(tpsf_pkg::REG_REST, 31'($urandom));
		write_reg(tpsf_pkg::REG_K, 31'($urandom_range(0, 32'h0010_0000)));
		random_words(120);
		wait_idle();
		repeat (100) @(posedge clk);

		if (fails == 0) begin
			$display("tb_two_point_spring_force: PASS");
		end else begin
			$display("tb_two_point_spring_force: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tpsf_pkg.sv
hdl/tpsf_sqrt.sv
hdl/tpsf_div.sv
hdl/two_point_spring_force.sv
hdl/tpsf_check.sv
test/tb_two_point_spring_force.sv
